// File: rtl/ptc_pkg.sv
package ptc_pkg;

  localparam int DIV_W   = 64;
  localparam int PRE_ST  = 11;
  localparam int POST_ST = 4;
  localparam int NSTAGE  = PRE_ST + DIV_W + POST_ST;

  localparam logic [63:0] FINE_OFFSET = 64'd128000;
  localparam logic [63:0] PRESS_FULL  = 64'd1048576;
  localparam logic [63:0] PRESS_SCALE = 64'd3125;

  typedef enum logic [1:0] {
    REG_TEMP_TRIM  = 2'd0,
    REG_PRESS_LOW  = 2'd1,
    REG_PRESS_HIGH = 2'd2,
    REG_PRESS_LAST = 2'd3
  } cfg_idx_t;

  // low 64 bits of a 64x64 product from three 32x32 partials
  function automatic logic [63:0] mul64(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] ll;
    logic [63:0] lh;
    logic [63:0] hl;
    ll = {32'd0, a[31:0]} * {32'd0, b[31:0]};
    lh = {32'd0, a[31:0]} * {32'd0, b[63:32]};
    hl = {32'd0, a[63:32]} * {32'd0, b[31:0]};
    return ll + {lh[31:0] + hl[31:0], 32'd0};
  endfunction

  function automatic logic [63:0] sx16(input logic [15:0] w);
    return {{48{w[15]}}, w};
  endfunction

endpackage

// File: rtl/pressure_temperature_compensation.sv
// channel | fields (low bit up)                                      | handshake
// in_     | tdata: raw_temperature[19:0], raw_pressure[39:20]        | tvalid/tready
// out_    | tdata: temperature_centi[31:0], pressure_q24_8[63:32];   | tvalid/tready
//         | tuser: pressure_valid                                    |
// cfg_    | we, addr (register index), wdata                         | write only
// One request per cycle while the output is not stalled; the 64-stage
// restoring divider sets the depth. The whole pipe advances together and
// freezes while out_tvalid is high and out_tready low. Synchronous active-low
// reset clears valid bits and trim registers.
module pressure_temperature_compensation (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [63:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // raw_temperature, raw_pressure
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // temperature_centi, pressure_q24_8
  output logic        out_tuser   // pressure_valid
);
  import ptc_pkg::*;

  logic [47:0] temp_trim_r;
  logic [63:0] press_low_r, press_high_r;
  logic [15:0] press_last_r;
  logic [NSTAGE-1:0] vld_r;
  logic en;

  logic [31:0] t1, t2, t3;
  logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;

  assign t1 = {16'd0, temp_trim_r[15:0]};
  assign t2 = {{16{temp_trim_r[31]}}, temp_trim_r[31:16]};
  assign t3 = {{16{temp_trim_r[47]}}, temp_trim_r[47:32]};
  assign p1 = {48'd0, press_low_r[15:0]};
  assign p2 = sx16(press_low_r[31:16]);
  assign p3 = sx16(press_low_r[47:32]);
  assign p4 = sx16(press_low_r[63:48]);
  assign p5 = sx16(press_high_r[15:0]);
  assign p6 = sx16(press_high_r[31:16]);
  assign p7 = sx16(press_high_r[47:32]);
  assign p8 = sx16(press_high_r[63:48]);
  assign p9 = sx16(press_last_r);

  assign en         = !out_tvalid || out_tready;
  assign in_tready  = en;
  assign out_tvalid = vld_r[NSTAGE-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_trim_r  <= '0;
      press_low_r  <= '0;
      press_high_r <= '0;
      press_last_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        REG_TEMP_TRIM:  temp_trim_r  <= cfg_wdata[47:0];
        REG_PRESS_LOW:  press_low_r  <= cfg_wdata;
        REG_PRESS_HIGH: press_high_r <= cfg_wdata;
        REG_PRESS_LAST: press_last_r <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (en) vld_r <= {vld_r[NSTAGE-2:0], in_tvalid};
  end

  // temperature path (32-bit wrap), then pressure numerator and divisor (64-bit)
  logic [31:0] d1_r, d2_r, m1_r, m2_r, a_r, m3_r, fine_r;
  logic [31:0] tmp5_r, tmp6_r, tmp7_r, tmp8_r, tmp9_r, tmp10_r;
  logic [19:0] adp1_r, adp2_r, adp3_r, adp4_r, adp5_r, adp6_r, adp7_r, adp8_r;
  logic [31:0] t5;
  logic [63:0] x_r, xx_r, xp5_r, xp2_r, y1_r, x1_r, y_r, xp5d_r, xp2d_r, v_r;
  logic [63:0] xd_r, xd10_r, num0_r, num_r, xm;

  assign t5 = fine_r * 32'd5 + 32'd128;
  assign xm = mul64(v_r, p1);

  always_ff @(posedge clk) begin
    if (en) begin
      d1_r   <= {15'd0, in_tdata[19:3]} - {15'd0, t1[15:0], 1'b0};
      d2_r   <= {16'd0, in_tdata[19:4]} - t1;
      adp1_r <= in_tdata[39:20];
      m1_r   <= d1_r * t2;
      m2_r   <= d2_r * d2_r;
      adp2_r <= adp1_r;
      a_r    <= $signed(m1_r) >>> 11;
      m3_r   <= 32'($signed(m2_r) >>> 12) * t3;
      adp3_r <= adp2_r;
      fine_r <= a_r + 32'($signed(m3_r) >>> 14);
      adp4_r <= adp3_r;
      tmp5_r <= $signed(t5) >>> 8;
      x_r    <= {{32{fine_r[31]}}, fine_r} - FINE_OFFSET;
      adp5_r <= adp4_r;
      xx_r   <= mul64(x_r, x_r);
      xp5_r  <= mul64(x_r, p5);
      xp2_r  <= mul64(x_r, p2);
      tmp6_r <= tmp5_r;
      adp6_r <= adp5_r;
      y1_r   <= mul64(xx_r, p6);
      x1_r   <= mul64(xx_r, p3);
      xp5d_r <= xp5_r;
      xp2d_r <= xp2_r;
      tmp7_r <= tmp6_r;
      adp7_r <= adp6_r;
      y_r    <= y1_r + (xp5d_r << 17) + (p4 << 35);
      v_r    <= (64'd1 << 47) + 64'($signed(x1_r) >>> 8) + (xp2d_r << 12);
      tmp8_r <= tmp7_r;
      adp8_r <= adp7_r;
      xd_r   <= $signed(xm) >>> 33;
      tmp9_r <= tmp8_r;
      num0_r <= ((PRESS_FULL - {44'd0, adp8_r}) << 31) - y_r;
      xd10_r <= xd_r;
      tmp10_r <= tmp9_r;
      num_r  <= mul64(num0_r, PRESS_SCALE);
    end
  end

  // restoring divider on magnitudes, one quotient bit per stage
  logic [63:0] dv_num_r [DIV_W+1];
  logic [63:0] dv_den_r [DIV_W+1];
  logic [63:0] dv_rem_r [DIV_W+1];
  logic        dv_neg_r [DIV_W+1];
  logic        dv_ok_r  [DIV_W+1];
  logic [31:0] dv_tmp_r [DIV_W+1];

  always_ff @(posedge clk) begin
    if (en) begin
      dv_num_r[0] <= num_r[63] ? 64'd0 - num_r : num_r;
      dv_den_r[0] <= xd10_r[63] ? 64'd0 - xd10_r : xd10_r;
      dv_rem_r[0] <= '0;
      dv_neg_r[0] <= num_r[63] ^ xd10_r[63];
      dv_ok_r[0]  <= xd10_r != 64'd0;
      dv_tmp_r[0] <= tmp10_r;
    end
  end

  for (genvar k = 0; k < DIV_W; k++) begin : g_div
    logic [64:0] sh;
    logic [64:0] df;
    assign sh = {dv_rem_r[k], dv_num_r[k][63]};
    assign df = sh - {1'b0, dv_den_r[k]};
    always_ff @(posedge clk) begin
      if (en) begin
        dv_rem_r[k+1] <= df[64] ? sh[63:0] : df[63:0];
        dv_num_r[k+1] <= {dv_num_r[k][62:0], !df[64]};
        dv_den_r[k+1] <= dv_den_r[k];
        dv_neg_r[k+1] <= dv_neg_r[k];
        dv_ok_r[k+1]  <= dv_ok_r[k];
        dv_tmp_r[k+1] <= dv_tmp_r[k];
      end
    end
  end

  // pressure correction
  logic [63:0] p_r, pa_r, pb_r, q13_r, tq_r, e0_r, c_r, e_r;
  logic [63:0] q13, pf;
  logic [31:0] tq_tmp_r, ta_r, tb_r;
  logic        oka_r, okq_r, okb_r;
  logic [31:0] out_temp_r, out_press_r;
  logic        out_ok_r;

  assign q13 = $signed(p_r) >>> 13;
  assign pf  = 64'($signed(pb_r + c_r + e_r) >>> 8) + (p7 << 4);

  always_ff @(posedge clk) begin
    if (en) begin
      p_r      <= dv_neg_r[DIV_W] ? 64'd0 - dv_num_r[DIV_W] : dv_num_r[DIV_W];
      okq_r    <= dv_ok_r[DIV_W];
      tq_tmp_r <= dv_tmp_r[DIV_W];
      tq_r     <= mul64(p9, q13);
      e0_r     <= mul64(p8, p_r);
      q13_r    <= q13;
      pa_r     <= p_r;
      oka_r    <= okq_r;
      ta_r     <= tq_tmp_r;
      c_r      <= $signed(mul64(tq_r, q13_r)) >>> 25;
      e_r      <= $signed(e0_r) >>> 19;
      pb_r     <= pa_r;
      okb_r    <= oka_r;
      tb_r     <= ta_r;
      out_press_r <= okb_r ? pf[31:0] : 32'd0;
      out_ok_r    <= okb_r;
      out_temp_r  <= tb_r;
    end
  end

  assign out_tdata = {out_press_r, out_temp_r};
  assign out_tuser = out_ok_r;

endmodule

// File: tb/sv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ptc_pkg::*;

  localparam int LATENCY = 79;

  typedef struct packed {
    logic [31:0] temp_centi;
    logic [31:0] press_q24_8;
    logic        press_ok;
  } comp_result_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_addr;
  logic [63:0] cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;   // raw_temperature, raw_pressure
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;  // temperature_centi, pressure_q24_8
  logic        out_tuser;  // pressure_valid

  logic [47:0] trim_t;
  logic [63:0] trim_p_lo;
  logic [63:0] trim_p_hi;
  logic [15:0] trim_p9;

  comp_result_t expected_q[$];
  int  error_count;
  bit  gaps_on;
  bit  hold_off;

  pressure_temperature_compensation dut (.*);

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic logic signed [63:0] sw16(logic [15:0] w);
    return {{48{w[15]}}, w};
  endfunction

  function automatic logic signed [63:0] div_trunc(logic signed [63:0] n,
                                                    logic signed [63:0] d);
    logic [63:0] mn;
    logic [63:0] md;
    logic [63:0] q;
    mn = n[63] ? -n : n;
    md = d[63] ? -d : d;
    q = mn / md;
    return (n[63] != d[63]) ? -q : q;
  endfunction

  function automatic comp_result_t compensate(logic [19:0] adc_t, logic [19:0] adc_p);
    comp_result_t r;
    logic signed [31:0] t1, t2, t3, d1, a, d2, b, fine, tc;
    logic signed [63:0] x, y, p, q, c, e;
    t1 = {16'd0, trim_t[15:0]};
    t2 = {{16{trim_t[31]}}, trim_t[31:16]};
    t3 = {{16{trim_t[47]}}, trim_t[47:32]};
    d1 = $signed({15'd0, adc_t[19:3]}) - (t1 <<< 1);
    a = (d1 * t2) >>> 11;
    d2 = $signed({16'd0, adc_t[19:4]}) - t1;
    b = (((d2 * d2) >>> 12) * t3) >>> 14;
    fine = a + b;
    tc = (fine * 32'sd5 + 32'sd128) >>> 8;
    x = 64'(fine) - 64'sd128000;
    y = x * x * sw16(trim_p_hi[31:16]);
    y = y + ((x * sw16(trim_p_hi[15:0])) <<< 17);
    y = y + (sw16(trim_p_lo[63:48]) <<< 35);
    x = ((x * x * sw16(trim_p_lo[47:32])) >>> 8) + ((x * sw16(trim_p_lo[31:16])) <<< 12);
    x = (((64'sd1 <<< 47) + x) * $signed({48'd0, trim_p_lo[15:0]})) >>> 33;
    r.temp_centi = tc;
    r.press_q24_8 = '0;
    r.press_ok = 1'b0;
    if (x != 0) begin
      p = 64'sd1048576 - $signed({44'd0, adc_p});
      p = div_trunc(((p <<< 31) - y) * 64'sd3125, x);
      q = p >>> 13;
      c = (sw16(trim_p9) * q * q) >>> 25;
      e = (sw16(trim_p_hi[63:48]) * p) >>> 19;
      p = ((p + c + e) >>> 8) + (sw16(trim_p_hi[47:32]) <<< 4);
      r.press_q24_8 = p[31:0];
      r.press_ok = 1'b1;
    end
    return r;
  endfunction

  task automatic idle_gap();
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  task automatic send_sample(logic [19:0] adc_t, logic [19:0] adc_p);
    idle_gap();
    in_tvalid <= 1'b1;
    in_tdata <= {adc_p, adc_t};
    do @(posedge clk); while (!in_tready);
    expected_q.push_back(compensate(adc_t, adc_p));
  endtask

  task automatic drain();
    int n;
    n = 0;
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0 && n < 200000) begin
      @(posedge clk);
      n++;
    end
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic write_trim(cfg_idx_t idx, logic [63:0] v);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    case (idx)
      REG_TEMP_TRIM:  trim_t = v[47:0];
      REG_PRESS_LOW:  trim_p_lo = v;
      REG_PRESS_HIGH: trim_p_hi = v;
      REG_PRESS_LAST: trim_p9 = v[15:0];
    endcase
  endtask

  task automatic load_trim(logic [47:0] t, logic [63:0] lo, logic [63:0] hi,
                           logic [15:0] p9);
    drain();
    write_trim(REG_TEMP_TRIM, {16'd0, t});
    write_trim(REG_PRESS_LOW, lo);
    write_trim(REG_PRESS_HIGH, hi);
    write_trim(REG_PRESS_LAST, {48'd0, p9});
    cfg_we <= 1'b0;
  endtask

  task automatic load_random_trim();
    load_trim({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
              16'($urandom));
  endtask

  // typical factory trim
  task automatic load_typical_trim();
    load_trim({16'hFC18, 16'd26435, 16'd27504},
              {16'd2855, 16'hFF8B, 16'hD7D0, 16'd36477},
              {16'd15500, 16'hFFF9, 16'hFFF9, 16'd140}, 16'd6000);
  endtask

  task automatic test_directed();
    load_typical_trim();
    send_sample(20'd519888, 20'd415148);
    send_sample(20'h00000, 20'h00000);
    send_sample(20'hFFFFF, 20'hFFFFF);
    send_sample(20'h00000, 20'hFFFFF);
    send_sample(20'hFFFFF, 20'h00000);
    send_sample(20'h80000, 20'h80000);
    load_trim('0, '0, '0, '0);
    send_sample(20'd519888, 20'd415148);
    load_trim('1, '1, '1, '1);
    send_sample(20'hFFFFF, 20'h00000);
    send_sample(20'h00000, 20'hFFFFF);
    load_trim({16'h7FFF, 16'h8000, 16'hFFFF}, {16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF},
              {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF}, 16'h8000);
    send_sample(20'hFFFFF, 20'hFFFFF);
    send_sample(20'h00000, 20'h00000);
    send_sample(20'h55555, 20'hAAAAA);
    load_trim({16'h8000, 16'h7FFF, 16'h0000}, {16'h8000, 16'h7FFF, 16'h8000, 16'h0001},
              {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000}, 16'h7FFF);
    send_sample(20'hAAAAA, 20'h55555);
    send_sample(20'hFFFFF, 20'h00001);
  endtask

  task automatic test_random_trim();
    for (int s = 0; s < 10; s++) begin
      load_random_trim();
      for (int i = 0; i < 40; i++) send_sample(20'($urandom), 20'($urandom));
    end
  endtask

  task automatic test_typical_readings();
    load_typical_trim();
    for (int i = 0; i < 300; i++)
      send_sample(20'($urandom_range(400000, 600000)), 20'($urandom_range(200000, 600000)));
  endtask

  task automatic test_backpressure();
    load_random_trim();
    hold_off = 1'b1;
    for (int i = 0; i < 150; i++) send_sample(20'($urandom), 20'($urandom));
  endtask

  task automatic test_full_rate();
    load_typical_trim();
    gaps_on = 1'b0;
    for (int i = 0; i < 100; i++) send_sample(20'($urandom), 20'($urandom));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_off) begin
      out_tready <= 1'b0;
      repeat (300) @(posedge clk);
      hold_off = 1'b0;
      out_tready <= 1'b1;
    end else if (gaps_on && $urandom_range(0, 5) == 0) begin
      out_tready <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
      out_tready <= 1'b1;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    comp_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %h/%b", $time, out_tdata, out_tuser);
        error_count++;
      end else begin
        want = expected_q.pop_front();
        if (out_tdata[31:0] !== want.temp_centi) begin
          $display("%0t: temperature expected %h actual %h", $time, want.temp_centi,
                   out_tdata[31:0]);
          error_count++;
        end
        if (out_tdata[63:32] !== want.press_q24_8) begin
          $display("%0t: pressure expected %h actual %h", $time, want.press_q24_8,
                   out_tdata[63:32]);
          error_count++;
        end
        if (out_tuser !== want.press_ok) begin
          $display("%0t: valid flag expected %b actual %b", $time, want.press_ok,
                   out_tuser);
          error_count++;
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    error_count = 0;
    gaps_on = 1'b1;
    hold_off = 1'b0;
    trim_t = '0;
    trim_p_lo = '0;
    trim_p_hi = '0;
    trim_p9 = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_trim();
    test_typical_readings();
    test_backpressure();
    test_full_rate();
    drain();
    if (expected_q.size() != 0) error_count++;
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

// File: sim.f
rtl/ptc_pkg.sv
rtl/pressure_temperature_compensation.sv
tb/sv/testbench.sv
